// ===== src/bxavg_pkg.sv =====
// ----------------------------------------------------------------------------
// bxavg_pkg
// Shared types and constants for the box average downscaler: beat payloads,
// configuration register indexes and their reset values.
// ----------------------------------------------------------------------------
package bxavg_pkg;

   // one raster pixel in
   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } pixel_in_type;

   // one averaged pixel out
   typedef struct packed {
      logic [7:0]  red_avg;
      logic [7:0]  green_avg;
      logic [7:0]  blue_avg;
      logic [11:0] out_col;
      logic [11:0] out_row;
      logic        frame_done;
   } pixel_out_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHRINK_FACTOR = 2'd2;

   localparam logic [12:0] RESET_IMAGE_WIDTH   = 13'd640;
   localparam logic [12:0] RESET_IMAGE_HEIGHT  = 13'd480;
   localparam logic [4:0]  RESET_SHRINK_FACTOR = 5'd2;

   localparam int MAX_HEIGHT = 4096;
   localparam int ROW_W      = 12;
   localparam int HEIGHT_W   = 13;

endpackage

// ===== src/bxavg_sum_ram.sv =====
// ----------------------------------------------------------------------------
// bxavg_sum_ram
// Line store of per-output-column channel sums: one write port and one read
// port, read data registered.
// ----------------------------------------------------------------------------
module bxavg_sum_ram #(
   parameter int DEPTH  = 4096,
   parameter int DATA_W = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bxavg_divider.sv =====
// ----------------------------------------------------------------------------
// bxavg_divider
// Shift-subtract divider for the three channel sums of one square, one
// quotient bit per cycle, all three channels in step against one divisor.
// ----------------------------------------------------------------------------
module bxavg_divider #(
   parameter int NUM_W = 16,
   parameter int DEN_W = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2:0][NUM_W-1:0] num,
   input  logic [DEN_W-1:0]      den,
   output logic                  done,
   output logic [2:0][NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [DEN_W-1:0]      den_ff;
   logic [2:0][DEN_W-1:0] rem_ff;
   logic [2:0][NUM_W-1:0] quo_ff;
   logic [2:0][DEN_W-1:0] rem_in;
   logic [2:0][NUM_W-1:0] quo_in;

   always_comb begin
      logic [DEN_W:0] trial;
      for (int c = 0; c < 3; c++) begin
         trial = {rem_ff[c], quo_ff[c][NUM_W-1]};
         if (trial >= {1'b0, den_ff}) begin
            rem_in[c] = DEN_W'(trial - {1'b0, den_ff});
            quo_in[c] = {quo_ff[c][NUM_W-2:0], 1'b1};
         end else begin
            rem_in[c] = trial[DEN_W-1:0];
            quo_in[c] = {quo_ff[c][NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_W'(NUM_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
         rem_ff <= '0;
         quo_ff <= num;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== src/box_average_downscale.sv =====
// ----------------------------------------------------------------------------
// box_average_downscale
// Integer box-filter downscaler: per-channel floor mean over each factor by
// factor square of a raster RGB stream, one output beat per whole square.
// ----------------------------------------------------------------------------
// pixel inside a whole square: sum memory read on accept, then merge and write
// pixel outside every whole square: counters only
// pixel that ends a square: merge, then the divider works one quotient bit per cycle over
//   SUM_W = 8 + 2*clog2(MAX_FACTOR) bits; rsp_valid rises once it is done and the output is free
// synchronous reset clears position counters and control, registers go to
//   640 x 480 with factor 2; the sum memory is not cleared (first pixel writes)
module box_average_downscale #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_FACTOR = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bxavg_pkg::pixel_in_type             req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bxavg_pkg::pixel_out_type            rsp_data,
   input  logic                                csr_we,
   input  logic [bxavg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bxavg_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WW    = CW + 1;
   localparam int XW    = WW + 1;
   localparam int SW    = $clog2(MAX_FACTOR);
   localparam int FW    = SW + 1;
   localparam int AREAW = 2 * FW;
   localparam int SUM_W = 8 + 2 * SW;
   localparam int RW    = bxavg_pkg::ROW_W;
   localparam int HW    = bxavg_pkg::HEIGHT_W;
   localparam int HXW   = HW + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MERGE,
      ST_DIVIDE
   } state_type;

   // configuration
   logic [12:0] width_ff;
   logic [12:0] height_ff;
   logic [4:0]  factor_ff;
   logic [WW-1:0] w_val;
   logic [HW-1:0] h_val;
   logic [FW-1:0] f_val;
   logic          csr_hit;

   // raster position
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] ocol_ff, ocol_in;
   logic [CW-1:0] sqc_ff, sqc_in;
   logic [SW-1:0] sub_col_ff, sub_col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [RW-1:0] orow_ff, orow_in;
   logic [RW-1:0] sqr_ff, sqr_in;
   logic [SW-1:0] sub_row_ff, sub_row_in;

   logic col_wrap, row_wrap, col_last, row_last;
   logic col_ok, row_ok, in_square, first_px, last_px, col_end, row_end;
   logic req_accept;

   // item held for the merge
   state_type               state_ff;
   logic [2:0][7:0]         pix_ff;
   logic [CW-1:0]           idx_ff;
   logic [RW-1:0]           item_row_ff;
   logic                    first_ff;
   logic                    emit_ff;
   logic                    done_ff;

   logic                    rsp_valid_ff;
   bxavg_pkg::pixel_out_type rsp_data_ff;

   logic [3*SUM_W-1:0]      rd_word;
   logic [2:0][SUM_W-1:0]   rd_sum;
   logic [2:0][SUM_W-1:0]   new_sum;
   logic [2:0][SUM_W-1:0]   quo;
   logic [AREAW-1:0]        area;
   logic                    wr_en, rd_en, div_start, div_done, out_free, out_load;

   // ---------------------------------------------------------------- config
   assign csr_hit = csr_we && (csr_index == bxavg_pkg::CSR_IMAGE_WIDTH ||
                               csr_index == bxavg_pkg::CSR_IMAGE_HEIGHT ||
                               csr_index == bxavg_pkg::CSR_SHRINK_FACTOR);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bxavg_pkg::RESET_IMAGE_WIDTH;
         height_ff <= bxavg_pkg::RESET_IMAGE_HEIGHT;
         factor_ff <= bxavg_pkg::RESET_SHRINK_FACTOR;
      end else if (csr_we) begin
         case (csr_index)
            bxavg_pkg::CSR_IMAGE_WIDTH:   width_ff  <= csr_wdata;
            bxavg_pkg::CSR_IMAGE_HEIGHT:  height_ff <= csr_wdata;
            bxavg_pkg::CSR_SHRINK_FACTOR: factor_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // zero acts as one, oversize saturates
   always_comb begin
      if (width_ff == '0) begin
         w_val = WW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_val = WW'(MAX_WIDTH);
      end else begin
         w_val = WW'(width_ff);
      end
      if (height_ff == '0) begin
         h_val = HW'(1);
      end else if (32'(height_ff) > bxavg_pkg::MAX_HEIGHT) begin
         h_val = HW'(bxavg_pkg::MAX_HEIGHT);
      end else begin
         h_val = height_ff;
      end
      if (factor_ff == '0) begin
         f_val = FW'(1);
      end else if (32'(factor_ff) > MAX_FACTOR) begin
         f_val = FW'(MAX_FACTOR);
      end else begin
         f_val = FW'(factor_ff);
      end
   end

   // -------------------------------------------------------------- position
   assign req_accept = req_valid && req_ready;

   assign col_wrap = (FW'(sub_col_ff) + 1'b1) >= f_val;
   assign row_wrap = (FW'(sub_row_ff) + 1'b1) >= f_val;
   assign col_last = (WW'(col_ff) + 1'b1) >= w_val;
   assign row_last = (HW'(row_ff) + 1'b1) >= h_val;

   // square is whole when its start plus the factor stays inside the image
   assign col_ok    = (XW'(sqc_ff) + XW'(f_val)) <= XW'(w_val);
   assign row_ok    = (HXW'(sqr_ff) + HXW'(f_val)) <= HXW'(h_val);
   assign col_end   = (XW'(sqc_ff) + XW'(f_val) + XW'(f_val)) > XW'(w_val);
   assign row_end   = (HXW'(sqr_ff) + HXW'(f_val) + HXW'(f_val)) > HXW'(h_val);
   assign in_square = col_ok && row_ok;
   assign first_px  = (sub_col_ff == '0) && (sub_row_ff == '0);
   assign last_px   = col_wrap && row_wrap;

   always_comb begin
      col_in     = col_ff;
      ocol_in    = ocol_ff;
      sqc_in     = sqc_ff;
      sub_col_in = sub_col_ff;
      row_in     = row_ff;
      orow_in    = orow_ff;
      sqr_in     = sqr_ff;
      sub_row_in = sub_row_ff;
      if (csr_hit) begin
         col_in     = '0;
         ocol_in    = '0;
         sqc_in     = '0;
         sub_col_in = '0;
         row_in     = '0;
         orow_in    = '0;
         sqr_in     = '0;
         sub_row_in = '0;
      end else if (req_accept) begin
         if (col_last) begin
            col_in     = '0;
            ocol_in    = '0;
            sqc_in     = '0;
            sub_col_in = '0;
            if (row_last) begin
               row_in     = '0;
               orow_in    = '0;
               sqr_in     = '0;
               sub_row_in = '0;
            end else begin
               row_in = row_ff + 1'b1;
               if (row_wrap) begin
                  sub_row_in = '0;
                  orow_in    = orow_ff + 1'b1;
                  sqr_in     = RW'(sqr_ff + RW'(f_val));
               end else begin
                  sub_row_in = sub_row_ff + 1'b1;
               end
            end
         end else begin
            col_in = col_ff + 1'b1;
            if (col_wrap) begin
               sub_col_in = '0;
               ocol_in    = ocol_ff + 1'b1;
               sqc_in     = CW'(sqc_ff + CW'(f_val));
            end else begin
               sub_col_in = sub_col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         ocol_ff    <= '0;
         sqc_ff     <= '0;
         sub_col_ff <= '0;
         row_ff     <= '0;
         orow_ff    <= '0;
         sqr_ff     <= '0;
         sub_row_ff <= '0;
      end else begin
         col_ff     <= col_in;
         ocol_ff    <= ocol_in;
         sqc_ff     <= sqc_in;
         sub_col_ff <= sub_col_in;
         row_ff     <= row_in;
         orow_ff    <= orow_in;
         sqr_ff     <= sqr_in;
         sub_row_ff <= sub_row_in;
      end
   end

   // ------------------------------------------------------- read-modify-write
   always_ff @(posedge clock) begin
      if (req_accept) begin
         pix_ff      <= {req_data.blue_in, req_data.green_in, req_data.red_in};
         idx_ff      <= ocol_ff;
         item_row_ff <= orow_ff;
         first_ff    <= first_px;
         emit_ff     <= last_px;
         done_ff     <= col_end && row_end;
      end
   end

   assign rd_en = req_accept && in_square;
   assign wr_en = (state_ff == ST_MERGE);
   assign rd_sum = rd_word;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (first_ff) begin
            new_sum[c] = SUM_W'(pix_ff[c]);
         end else begin
            new_sum[c] = rd_sum[c] + SUM_W'(pix_ff[c]);
         end
      end
   end

   bxavg_sum_ram #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (3 * SUM_W)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (new_sum),
      .rd_en   (rd_en),
      .rd_addr (ocol_ff),
      .rd_data (rd_word)
   );

   // ------------------------------------------------------------------ divide
   assign area      = AREAW'(f_val) * AREAW'(f_val);
   assign div_start = (state_ff == ST_MERGE) && emit_ff;

   bxavg_divider #(
      .NUM_W (SUM_W),
      .DEN_W (AREAW)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (new_sum),
      .den   (area),
      .done  (div_done),
      .quo   (quo)
   );

   // --------------------------------------------------------- control, output
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign out_load = (state_ff == ST_DIVIDE) && div_done && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept && in_square) begin
                  state_ff <= ST_MERGE;
               end
            end
            ST_MERGE: begin
               state_ff <= emit_ff ? ST_DIVIDE : ST_IDLE;
            end
            ST_DIVIDE: begin
               // hold the quotients until the output beat slot is free
               if (out_load) begin
                  rsp_data_ff.red_avg    <= quo[0][7:0];
                  rsp_data_ff.green_avg  <= quo[1][7:0];
                  rsp_data_ff.blue_avg   <= quo[2][7:0];
                  rsp_data_ff.out_col    <= 12'(idx_ff);
                  rsp_data_ff.out_row    <= item_row_ff;
                  rsp_data_ff.frame_done <= done_ff;
                  state_ff               <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // -------------------------------------------------------------- assertions
   a_no_rw_overlap : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !rd_en)
      else $error("sum memory read and write in the same cycle");

   a_merge_no_emit : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE && !emit_ff) |=> (state_ff == ST_IDLE))
      else $error("merge without square end did not return to idle");

   a_result_held : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && div_done && rsp_valid_ff && !rsp_ready)
      |=> (state_ff == ST_DIVIDE && div_done))
      else $error("finished average dropped while output beat stalled");

   a_sub_in_range : assert property (@(posedge clock) disable iff (reset)
      (FW'(sub_col_ff) < f_val) && (FW'(sub_row_ff) < f_val))
      else $error("square sub-position outside factor");

   a_restart : assert property (@(posedge clock) disable iff (reset)
      csr_hit |=> (col_ff == '0 && row_ff == '0 && ocol_ff == '0 && orow_ff == '0))
      else $error("register write did not restart the frame");

endmodule
